// ===== sv/spbp_pkg.sv =====
// Shared types and constants for the stream packet byte parser.
`default_nettype none

package spbp_pkg;

   localparam int LENGTH_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH         = 4;
   localparam int QUEUE_PTR_W         = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W         = $clog2(QUEUE_DEPTH + 1);

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 160;
   localparam int RSP_PAD_W  = 2;
   localparam int KIND_W     = 3;

   localparam logic [7:0] HDR_FORM_MASK    = 8'h80;
   localparam logic [7:0] FRAME_FLAGS_MASK = 8'h07;
   localparam logic [7:0] FRAME_STREAM     = 8'h08;
   localparam logic [2:0] FLAG_OFFSET      = 3'b100;
   localparam logic [2:0] FLAG_LENGTH      = 3'b010;
   localparam logic [2:0] FLAG_FIN         = 3'b001;
   localparam logic [7:0] VERSION_BYTES    = 8'd4;

   typedef enum logic [KIND_W-1:0] {
      KIND_HEADER  = 3'd0,
      KIND_DEST_ID = 3'd1,
      KIND_SRC_ID  = 3'd2,
      KIND_FRAME   = 3'd3,
      KIND_DATA    = 3'd4,
      KIND_END     = 3'd5
   } kind_type;

   // results caused by one input byte: an optional main result and an optional end status
   typedef struct packed {
      logic        has_main;
      kind_type    kind;
      logic [7:0]  value_byte;
      logic [2:0]  hdr_type;
      logic        short_header;
      logic [63:0] strm_id;
      logic [63:0] frame_offset;
      logic        fin;
      logic [15:0] data_length;
      logic        has_end;
      logic        accepted;
   } entry_type;

endpackage

`default_nettype wire

// ===== sv/spbp_parser.sv =====
// Front end: per-byte packet parse state machine, produces at most one queue entry per input byte.
`default_nettype none

module spbp_parser #(
   parameter int LENGTH_BITS = spbp_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic [7:0]          in_byte,
   input  logic                start,
   input  logic [15:0]         packet_length,
   output logic                push,
   output spbp_pkg::entry_type entry
);
   import spbp_pkg::*;

   typedef enum logic [13:0] {
      PH_IDLE   = 14'h0001,
      PH_VER    = 14'h0002,
      PH_DLEN   = 14'h0004,
      PH_DID    = 14'h0008,
      PH_SLEN   = 14'h0010,
      PH_SID    = 14'h0020,
      PH_FTYPE  = 14'h0040,
      PH_SIDLEN = 14'h0080,
      PH_SIDB   = 14'h0100,
      PH_OFFLEN = 14'h0200,
      PH_OFFB   = 14'h0400,
      PH_LLEN   = 14'h0800,
      PH_LB     = 14'h1000,
      PH_DATA   = 14'h2000
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [LENGTH_BITS-1:0] left_ff, left_in;
   logic                   stopped_ff, stopped_in;
   logic [7:0]             count_ff, count_in;
   logic [63:0]            sid_ff, sid_in;
   logic [63:0]            off_ff, off_in;
   logic [63:0]            len_ff, len_in;
   logic [LENGTH_BITS-1:0] dcount_ff, dcount_in;
   logic [2:0]             flags_ff, flags_in;

   logic [LENGTH_BITS-1:0] pkt_len;
   logic [LENGTH_BITS-1:0] base_left;
   logic [LENGTH_BITS-1:0] rem;
   logic [LENGTH_BITS-1:0] byte_w;
   logic [LENGTH_BITS-1:0] frame_dlen;
   logic                   frame_go;
   logic                   active;

   assign pkt_len = LENGTH_BITS'(packet_length);
   assign byte_w  = LENGTH_BITS'(in_byte);
   assign active  = start || (phase_ff != PH_IDLE);

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      sid_in     = sid_ff;
      off_in     = off_ff;
      len_in     = len_ff;
      dcount_in  = dcount_ff;
      flags_in   = flags_ff;
      stopped_in = stopped_ff;
      entry      = '0;
      frame_go   = 1'b0;
      frame_dlen = '0;

      base_left = left_ff;
      if (start) begin
         base_left = (pkt_len == '0) ? LENGTH_BITS'(1) : pkt_len;
      end
      rem = base_left - LENGTH_BITS'(1);

      if (start) begin
         count_in         = '0;
         sid_in           = '0;
         off_in           = '0;
         len_in           = '0;
         dcount_in        = '0;
         flags_in         = '0;
         stopped_in       = 1'b0;
         entry.has_main   = 1'b1;
         entry.kind       = KIND_HEADER;
         if ((in_byte & HDR_FORM_MASK) == '0) begin
            entry.hdr_type = in_byte[6:4];
            count_in       = VERSION_BYTES;
            phase_in       = PH_VER;
         end else begin
            entry.short_header = 1'b1;
            phase_in           = PH_FTYPE;
         end
      end else if (!stopped_ff) begin
         unique case (phase_ff)
            PH_VER: begin
               count_in = count_ff - 8'd1;
               if (count_ff == 8'd1) phase_in = PH_DLEN;
            end
            PH_DLEN: begin
               if (in_byte != '0 && byte_w <= rem) begin
                  count_in = in_byte;
                  phase_in = PH_DID;
               end else begin
                  phase_in = PH_SLEN;
               end
            end
            PH_SLEN: begin
               if (in_byte != '0 && byte_w <= rem) begin
                  count_in = in_byte;
                  phase_in = PH_SID;
               end else begin
                  phase_in = PH_FTYPE;
               end
            end
            PH_DID: begin
               entry.has_main   = 1'b1;
               entry.kind       = KIND_DEST_ID;
               entry.value_byte = in_byte;
               count_in         = count_ff - 8'd1;
               if (count_ff == 8'd1) phase_in = PH_SLEN;
            end
            PH_SID: begin
               entry.has_main   = 1'b1;
               entry.kind       = KIND_SRC_ID;
               entry.value_byte = in_byte;
               count_in         = count_ff - 8'd1;
               if (count_ff == 8'd1) phase_in = PH_FTYPE;
            end
            PH_FTYPE: begin
               if ((in_byte & FRAME_STREAM) != '0) begin
                  flags_in = 3'(in_byte & FRAME_FLAGS_MASK);
                  phase_in = PH_SIDLEN;
               end else begin
                  stopped_in = 1'b1;
               end
            end
            PH_SIDLEN: begin
               if (in_byte == '0 || byte_w > rem) begin
                  stopped_in = 1'b1;
               end else begin
                  count_in = in_byte;
                  sid_in   = '0;
                  phase_in = PH_SIDB;
               end
            end
            PH_SIDB: begin
               sid_in   = {sid_ff[55:0], in_byte};
               count_in = count_ff - 8'd1;
               if (count_ff == 8'd1) begin
                  off_in = '0;
                  if ((flags_ff & FLAG_OFFSET) != '0) begin
                     phase_in = PH_OFFLEN;
                  end else if ((flags_ff & FLAG_LENGTH) != '0) begin
                     phase_in = PH_LLEN;
                  end else begin
                     frame_go   = 1'b1;
                     frame_dlen = rem;
                  end
               end
            end
            PH_OFFLEN: begin
               if (byte_w > rem) begin
                  stopped_in = 1'b1;
               end else begin
                  off_in   = '0;
                  count_in = in_byte;
                  if (in_byte != '0) begin
                     phase_in = PH_OFFB;
                  end else if ((flags_ff & FLAG_LENGTH) != '0) begin
                     phase_in = PH_LLEN;
                  end else begin
                     frame_go   = 1'b1;
                     frame_dlen = rem;
                  end
               end
            end
            PH_OFFB: begin
               off_in   = {off_ff[55:0], in_byte};
               count_in = count_ff - 8'd1;
               if (count_ff == 8'd1) begin
                  if ((flags_ff & FLAG_LENGTH) != '0) begin
                     phase_in = PH_LLEN;
                  end else begin
                     frame_go   = 1'b1;
                     frame_dlen = rem;
                  end
               end
            end
            PH_LLEN: begin
               if (byte_w > rem) begin
                  stopped_in = 1'b1;
               end else begin
                  len_in   = '0;
                  count_in = in_byte;
                  if (in_byte == '0) begin
                     frame_go   = 1'b1;
                     frame_dlen = '0;
                  end else begin
                     phase_in = PH_LB;
                  end
               end
            end
            PH_LB: begin
               len_in   = {len_ff[55:0], in_byte};
               count_in = count_ff - 8'd1;
               if (count_ff == 8'd1) begin
                  frame_go   = 1'b1;
                  frame_dlen = (len_in <= 64'(rem)) ? LENGTH_BITS'(len_in) : '0;
               end
            end
            PH_DATA: begin
               entry.has_main   = 1'b1;
               entry.kind       = KIND_DATA;
               entry.value_byte = in_byte;
               dcount_in        = dcount_ff - LENGTH_BITS'(1);
               if (dcount_ff == LENGTH_BITS'(1)) phase_in = PH_FTYPE;
            end
            default: begin
               stopped_in = 1'b1;
            end
         endcase
      end

      if (frame_go) begin
         entry.has_main     = 1'b1;
         entry.kind         = KIND_FRAME;
         entry.strm_id      = sid_in;
         entry.frame_offset = off_in;
         entry.fin          = (flags_in & FLAG_FIN) != '0;
         entry.data_length  = 16'(frame_dlen);
         dcount_in          = frame_dlen;
         phase_in           = (frame_dlen != '0) ? PH_DATA : PH_FTYPE;
      end

      left_in = rem;
      if (rem == '0) begin
         entry.has_end  = 1'b1;
         entry.accepted = !(phase_in == PH_VER || phase_in == PH_DLEN ||
                            phase_in == PH_DID || phase_in == PH_SLEN);
         phase_in       = PH_IDLE;
         stopped_in     = 1'b0;
      end
   end

   assign push = take && active && (entry.has_main || entry.has_end);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         left_ff    <= '0;
         stopped_ff <= 1'b0;
      end else if (take && active) begin
         phase_ff   <= phase_in;
         left_ff    <= left_in;
         stopped_ff <= stopped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && active) begin
         count_ff  <= count_in;
         sid_ff    <= sid_in;
         off_ff    <= off_in;
         len_ff    <= len_in;
         dcount_ff <= dcount_in;
         flags_ff  <= flags_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/spbp_queue.sv =====
// Short FIFO of parsed entries between the parser and the result emitter.
`default_nettype none

module spbp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  spbp_pkg::entry_type push_entry,
   input  logic                pop,
   output logic                full,
   output logic                empty,
   output spbp_pkg::entry_type head
);
   import spbp_pkg::*;

   entry_type              slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ===== sv/spbp_emitter.sv =====
// Back end: splits each queue entry into one or two result items behind an output register.
`default_nettype none

module spbp_emitter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              head_valid,
   input  spbp_pkg::entry_type               head,
   output logic                              pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [spbp_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [spbp_pkg::KIND_W-1:0]       rsp_tuser,
   output logic                              rsp_tlast
);
   import spbp_pkg::*;

   logic                  valid_ff, valid_in;
   logic                  done_ff, done_in;
   kind_type              kind_ff, kind_in;
   logic [RSP_DATA_W-1:0] data_ff, data_in;
   logic                  last_ff, last_in;
   logic                  load;
   logic [RSP_DATA_W-1:0] main_data;
   logic [RSP_DATA_W-1:0] end_data;

   assign main_data = {{RSP_PAD_W{1'b0}}, 1'b0, head.data_length, head.fin,
                       head.frame_offset, head.strm_id, head.short_header,
                       head.hdr_type, head.value_byte};
   assign end_data  = {{RSP_PAD_W{1'b0}}, head.accepted, {(RSP_DATA_W - RSP_PAD_W - 1){1'b0}}};

   assign load = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      done_in  = done_ff;
      kind_in  = kind_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = head_valid;
         if (head_valid) begin
            if (head.has_main && !done_ff) begin
               kind_in = head.kind;
               data_in = main_data;
               last_in = !head.has_end;
               if (head.has_end) begin
                  done_in = 1'b1;
               end else begin
                  pop = 1'b1;
               end
            end else begin
               kind_in = KIND_END;
               data_in = end_data;
               last_in = 1'b1;
               done_in = 1'b0;
               pop     = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire

// ===== sv/stream_packet_byte_parser_unit.sv =====
// Packet byte parser top level: 4-entry parse queue between the parser and the result emitter.
// Takes one packet byte per cycle while the queue is not full and turns it into zero, one or two
// result items (header info, connection ID bytes, stream frame headers, data bytes, and an end
// status on the last byte of the packet). The parser settles each byte in the cycle it is
// accepted and writes its results as one entry into a 4-entry queue; the emitter drains one
// result per cycle while the receiver takes results, through an output register, so a result
// passes through a queue slot and the output register. req_tready drops only while the queue is full.
`default_nettype none

module stream_packet_byte_parser_unit #(
   parameter int LENGTH_BITS = spbp_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [spbp_pkg::REQ_DATA_W-1:0] req_tdata,   // in_byte[7:0], packet_length[23:8]
   input  logic                            req_tuser,   // start_of_packet
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // value_byte[7:0], hdr_type[10:8], short_header[11], strm_id[75:12],
   // frame_offset[139:76], fin[140], data_length[156:141], accepted[157], zero[159:158]
   output logic [spbp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [spbp_pkg::KIND_W-1:0]     rsp_tuser,   // kind
   output logic                            rsp_tlast    // last
);
   import spbp_pkg::*;

   logic      take;
   logic      q_push;
   logic      q_pop;
   logic      q_full;
   logic      q_empty;
   entry_type q_in;
   entry_type q_head;

   assign req_tready = !q_full;
   assign take       = req_tvalid && req_tready;

   spbp_parser #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .take          (take),
      .in_byte       (req_tdata[7:0]),
      .start         (req_tuser),
      .packet_length (req_tdata[23:8]),
      .push          (q_push),
      .entry         (q_in)
   );

   spbp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in),
      .pop        (q_pop),
      .full       (q_full),
      .empty      (q_empty),
      .head       (q_head)
   );

   spbp_emitter u_emitter (
      .clock      (clock),
      .reset      (reset),
      .head_valid (!q_empty),
      .head       (q_head),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef ASSERT_OFF
   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (take && !q_full))
      else $error("parse queue written while full or without an accepted item");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("parse queue read while empty");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_END) |-> rsp_tlast)
      else $error("end status item without last");

   a_not_last_then_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> (rsp_tvalid && rsp_tuser == KIND_END))
      else $error("item marked not last is not followed by an end status");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_stream_packet_byte_parser_unit.sv =====
// Self-checking testbench for the stream packet byte parser: per-byte prediction, in-order checks.
`default_nettype none

module tb_stream_packet_byte_parser_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import spbp_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 20;
   localparam int RANDOM_ITEMS = 1700;
   localparam int HOLD_CYCLES  = 300;

   typedef enum logic [3:0] {
      ST_IDLE, ST_VERSION, ST_DCID_LEN, ST_DCID, ST_SCID_LEN, ST_SCID, ST_FRAME_TYPE,
      ST_SID_LEN, ST_SID, ST_OFF_LEN, ST_OFF, ST_LEN_LEN, ST_LEN, ST_DATA
   } parse_state_type;

   typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_HICCUP} rx_mode_type;

   typedef struct {
      kind_type    kind;
      logic [7:0]  value_byte;
      logic [2:0]  hdr_type;
      logic        short_header;
      logic [63:0] strm_id;
      logic [63:0] frame_offset;
      logic        fin;
      logic [15:0] data_length;
      logic        accepted;
      logic        last;
   } parse_result_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [KIND_W-1:0]     rsp_tuser;
   logic                  rsp_tlast;

   stream_packet_byte_parser_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // parser state mirror
   parse_state_type pst;
   logic [15:0]     left;
   logic [7:0]      fcount;
   logic [63:0]     sid_acc;
   logic [63:0]     off_acc;
   logic [63:0]     len_acc;
   logic [2:0]      fflags;
   logic            halted;

   parse_result_type parsed_items[$];

   logic [7:0]  pkt_bytes[$];
   logic [15:0] pkt_len;

   int          error_count     = 0;
   int          results_checked = 0;
   int          frames_checked  = 0;
   int          ends_checked    = 0;
   int          packet_items    = 0;
   int          packets_sent    = 0;
   int          burst_left      = 0;
   bit          gaps_off        = 1'b0;
   int          hold_request    = 0;
   int          hold_left       = 0;
   int          mode_left       = 0;
   rx_mode_type stall_mode      = RX_OPEN;
   int unsigned cycle_count     = 0;

   function automatic parse_result_type fresh_item(kind_type k, logic [7:0] v);
      parse_result_type it;
      it.kind         = k;
      it.value_byte   = v;
      it.hdr_type     = '0;
      it.short_header = 1'b0;
      it.strm_id      = '0;
      it.frame_offset = '0;
      it.fin          = 1'b0;
      it.data_length  = '0;
      it.accepted     = 1'b0;
      it.last         = 1'b0;
      return it;
   endfunction

   function automatic void queue_result(parse_result_type it);
      parsed_items.insert(parsed_items.size(), it);
   endfunction

   function automatic void add_byte(logic [7:0] b);
      pkt_bytes.insert(pkt_bytes.size(), b);
   endfunction

   function automatic void reset_parser();
      pst     = ST_IDLE;
      left    = '0;
      fcount  = '0;
      sid_acc = '0;
      off_acc = '0;
      len_acc = '0;
      fflags  = '0;
      halted  = 1'b0;
   endfunction

   function automatic void emit_frame(logic [15:0] dl);
      parse_result_type it;
      it              = fresh_item(KIND_FRAME, 8'h00);
      it.strm_id      = sid_acc;
      it.frame_offset = off_acc;
      it.fin          = fflags[0];
      it.data_length  = dl;
      queue_result(it);
      len_acc = {48'd0, dl};
      if (dl != 0) pst = ST_DATA;
      else pst = ST_FRAME_TYPE;
   endfunction

   function automatic void after_offset(logic [15:0] rem);
      if ((fflags & FLAG_LENGTH) != 0) pst = ST_LEN_LEN;
      else emit_frame(rem);
   endfunction

   function automatic void finish_length(logic [15:0] rem);
      if (len_acc <= {48'd0, rem}) emit_frame(len_acc[15:0]);
      else emit_frame(16'd0);
   endfunction

   function automatic void parse_byte(logic [7:0] b, logic sop, logic [15:0] plen);
      int               first;
      logic [15:0]      rem;
      logic             rej;
      parse_result_type it;
      first = parsed_items.size();
      if (sop) begin
         reset_parser();
         left = (plen == 0) ? 16'd1 : plen;
      end else if (pst == ST_IDLE) begin
         return;
      end
      left = left - 16'd1;
      rem  = left;

      if (sop) begin
         it = fresh_item(KIND_HEADER, 8'h00);
         if ((b & HDR_FORM_MASK) == 0) begin
            it.hdr_type = b[6:4];
            fcount = VERSION_BYTES;
            pst = ST_VERSION;
         end else begin
            it.short_header = 1'b1;
            pst = ST_FRAME_TYPE;
         end
         queue_result(it);
      end else if (!halted) begin
         case (pst)
            ST_VERSION: begin
               fcount--;
               if (fcount == 0) pst = ST_DCID_LEN;
            end
            ST_DCID_LEN, ST_SCID_LEN: begin
               if (b != 0 && b <= rem) begin
                  fcount = b;
                  if (pst == ST_DCID_LEN) pst = ST_DCID;
                  else pst = ST_SCID;
               end else if (pst == ST_DCID_LEN) begin
                  pst = ST_SCID_LEN;
               end else begin
                  pst = ST_FRAME_TYPE;
               end
            end
            ST_DCID: begin
               queue_result(fresh_item(KIND_DEST_ID, b));
               fcount--;
               if (fcount == 0) pst = ST_SCID_LEN;
            end
            ST_SCID: begin
               queue_result(fresh_item(KIND_SRC_ID, b));
               fcount--;
               if (fcount == 0) pst = ST_FRAME_TYPE;
            end
            ST_FRAME_TYPE: begin
               if ((b & FRAME_STREAM) != 0) begin
                  fflags = b[2:0];
                  pst = ST_SID_LEN;
               end else begin
                  halted = 1'b1;
               end
            end
            ST_SID_LEN: begin
               if (b == 0 || b > rem) begin
                  halted = 1'b1;
               end else begin
                  fcount  = b;
                  sid_acc = '0;
                  pst     = ST_SID;
               end
            end
            ST_SID: begin
               sid_acc = {sid_acc[55:0], b};
               fcount--;
               if (fcount == 0) begin
                  off_acc = '0;
                  if ((fflags & FLAG_OFFSET) != 0) pst = ST_OFF_LEN;
                  else after_offset(rem);
               end
            end
            ST_OFF_LEN: begin
               if (b > rem) begin
                  halted = 1'b1;
               end else begin
                  off_acc = '0;
                  fcount  = b;
                  if (b == 0) after_offset(rem);
                  else pst = ST_OFF;
               end
            end
            ST_OFF: begin
               off_acc = {off_acc[55:0], b};
               fcount--;
               if (fcount == 0) after_offset(rem);
            end
            ST_LEN_LEN: begin
               if (b > rem) begin
                  halted = 1'b1;
               end else begin
                  len_acc = '0;
                  fcount  = b;
                  if (b == 0) finish_length(rem);
                  else pst = ST_LEN;
               end
            end
            ST_LEN: begin
               len_acc = {len_acc[55:0], b};
               fcount--;
               if (fcount == 0) finish_length(rem);
            end
            ST_DATA: begin
               queue_result(fresh_item(KIND_DATA, b));
               len_acc--;
               if (len_acc == 0) pst = ST_FRAME_TYPE;
            end
            default: halted = 1'b1;
         endcase
      end

      if (rem == 0) begin
         // long header cut off before the source ID length is rejected
         rej = (pst == ST_VERSION || pst == ST_DCID_LEN || pst == ST_DCID ||
                pst == ST_SCID_LEN);
         it = fresh_item(KIND_END, 8'h00);
         it.accepted = !rej;
         queue_result(it);
         pst    = ST_IDLE;
         halted = 1'b0;
      end
      if (parsed_items.size() > first) begin
         it = parsed_items.pop_back();
         it.last = 1'b1;
         queue_result(it);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) reset_parser();
      else if (req_tvalid && req_tready) parse_byte(req_tdata[7:0], req_tuser, req_tdata[23:8]);
   end

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      error_count++;
      if (error_count <= 40)
         $display("%0t ns: result %0d: %s got %0h expected %0h",
                  $realtime, results_checked, what, got, want);
   endtask

   always @(posedge clock) begin : check_results
      parse_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (parsed_items.size() == 0) begin
            report_mismatch("unexpected item, kind", rsp_tuser, 'x);
         end else begin
            want = parsed_items.pop_front();
            if (rsp_tuser !== want.kind) report_mismatch("kind", rsp_tuser, want.kind);
            if (rsp_tdata[7:0] !== want.value_byte)
               report_mismatch("value_byte", rsp_tdata[7:0], want.value_byte);
            if (rsp_tdata[10:8] !== want.hdr_type)
               report_mismatch("hdr_type", rsp_tdata[10:8], want.hdr_type);
            if (rsp_tdata[11] !== want.short_header)
               report_mismatch("short_header", rsp_tdata[11], want.short_header);
            if (rsp_tdata[75:12] !== want.strm_id)
               report_mismatch("strm_id", rsp_tdata[75:12], want.strm_id);
            if (rsp_tdata[139:76] !== want.frame_offset)
               report_mismatch("frame_offset", rsp_tdata[139:76], want.frame_offset);
            if (rsp_tdata[140] !== want.fin) report_mismatch("fin", rsp_tdata[140], want.fin);
            if (rsp_tdata[156:141] !== want.data_length)
               report_mismatch("data_length", rsp_tdata[156:141], want.data_length);
            if (rsp_tdata[157] !== want.accepted)
               report_mismatch("accepted", rsp_tdata[157], want.accepted);
            if (rsp_tdata[159:158] !== 2'b00)
               report_mismatch("padding", rsp_tdata[159:158], 0);
            if (rsp_tlast !== want.last) report_mismatch("last", rsp_tlast, want.last);
            if (want.kind == KIND_FRAME) frames_checked++;
            if (want.kind == KIND_END) ends_checked++;
         end
         results_checked++;
      end
   end

   // receiver: changing stall pattern, plus one long hold requested by the backpressure test
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (mode_left == 0) begin
         stall_mode = rx_mode_type'($urandom_range(0, 3));
         mode_left  = $urandom_range(20, 200);
      end else begin
         mode_left--;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (stall_mode)
            RX_OPEN:   rsp_tready <= 1'b1;
            RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
            default:   rsp_tready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, parsed_items.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic sop, input logic [15:0] plen);
      if (!gaps_off) begin
         if (burst_left == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            if ($urandom_range(0, 9) == 0) burst_left = $urandom_range(100, 300);
            else burst_left = $urandom_range(1, 20);
         end else begin
            burst_left--;
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {plen, b};
      req_tuser  <= sop;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_packet();
      int limit;
      limit = (pkt_len == 0) ? 1 : pkt_len;
      foreach (pkt_bytes[i]) begin
         send_byte(pkt_bytes[i], i == 0, (i == 0) ? pkt_len : 16'($urandom_range(0, 65535)));
         if (i < limit) packet_items++;
      end
      packets_sent++;
   endtask

   task automatic make_random_packet();
      int          n;
      int          nframes;
      int          ndata;
      int          shape;
      bit          all_ones;
      logic [2:0]  flags;
      logic [7:0]  ftype;
      logic [63:0] lenval;
      logic [63:0] tmp;
      pkt_bytes = {};
      if ($urandom_range(0, 11) == 0) begin
         n = $urandom_range(1, 30);
         repeat (n) add_byte(8'($urandom));
      end else begin
         if ($urandom_range(0, 1)) begin
            add_byte(8'($urandom_range(0, 127)));
            repeat (VERSION_BYTES) add_byte(8'($urandom));
            repeat (2) begin
               n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 20);
               add_byte(8'(n));
               repeat (n) add_byte(8'($urandom));
            end
         end else begin
            add_byte(8'($urandom_range(128, 255)));
         end
         nframes = $urandom_range(0, 3);
         for (int f = 0; f < nframes; f++) begin
            flags = 3'($urandom);
            if (f < nframes - 1) flags = flags | FLAG_LENGTH;
            ftype = 8'($urandom_range(0, 15) << 4) | FRAME_STREAM | {5'd0, flags};
            if ($urandom_range(0, 19) == 0) ftype = ftype & ~FRAME_STREAM;
            add_byte(ftype);
            n = $urandom_range(0, 19);
            if (n == 0) n = 0;
            else if (n <= 2) n = $urandom_range(9, 12);
            else n = $urandom_range(1, 8);
            add_byte(8'(n));
            all_ones = ($urandom_range(0, 3) == 0);
            repeat (n) add_byte(all_ones ? 8'hFF : 8'($urandom));
            if ((flags & FLAG_OFFSET) != 0) begin
               n = $urandom_range(0, 10);
               add_byte(8'(n));
               all_ones = ($urandom_range(0, 3) == 0);
               repeat (n) add_byte(all_ones ? 8'hFF : 8'($urandom));
            end
            ndata = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
            if ((flags & FLAG_LENGTH) != 0) begin
               lenval = 64'(ndata);
               if ($urandom_range(0, 7) == 0) lenval = {$urandom, $urandom};
               n   = 0;
               tmp = lenval;
               while (tmp != 0) begin
                  n++;
                  tmp = tmp >> 8;
               end
               n = n + $urandom_range(0, 2);
               add_byte(8'(n));
               for (int i = n - 1; i >= 0; i--)
                  add_byte((i < 8) ? lenval[8*i +: 8] : 8'h00);
            end
            repeat (ndata) add_byte(8'($urandom));
         end
      end
      pkt_len = 16'(pkt_bytes.size());
      shape = $urandom_range(0, 19);
      if (shape == 0) pkt_len = 16'($urandom_range(1, pkt_bytes.size()));
      else if (shape == 1) pkt_len = 16'($urandom_range(pkt_bytes.size() + 1, 65535));
      else if (shape == 2 && pkt_bytes.size() == 1) pkt_len = 0;
   endtask

   task automatic test_header_edges();
      pkt_bytes = '{8'h70};
      pkt_len = 16'd1;
      send_packet();
      pkt_bytes = '{8'h80};
      pkt_len = 16'd0;
      send_packet();
      pkt_bytes = '{8'hFF, 8'h00, 8'hFF};
      pkt_len = 16'd3;
      send_packet();
      send_byte(8'hA5, 1'b0, 16'hFFFF);
      pkt_bytes = '{8'h80, 8'h08};
      pkt_len = 16'hFFFF;
      send_packet();
   endtask

   task automatic test_long_header();
      pkt_bytes = '{8'h35, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'hFF, 8'h02, 8'h00, 8'h80,
                    8'h09, 8'h01, 8'h00};
      pkt_len = 16'd13;
      send_packet();
   endtask

   task automatic test_stream_frames();
      // full-flag frame, then an overrunning length, then a frame that takes the rest
      pkt_bytes = '{8'hC0,
                    8'h0F, 8'h01, 8'hFF, 8'h01, 8'h80, 8'h01, 8'h02, 8'hAA, 8'h55,
                    8'h0A, 8'h01, 8'h00, 8'h02, 8'hFF, 8'hFF,
                    8'h08, 8'h01, 8'h80, 8'h7E};
      pkt_len = 16'd20;
      send_packet();
   endtask

   task automatic test_backpressure();
      hold_request = HOLD_CYCLES;
      gaps_off = 1'b1;
      repeat (2) begin
         pkt_bytes = '{8'h80, 8'h08, 8'h01, 8'h42};
         repeat (20) add_byte(8'($urandom));
         pkt_len = 16'(pkt_bytes.size());
         send_packet();
      end
      gaps_off = 1'b0;
   endtask

   task automatic test_random_packets();
      int target;
      target = packet_items + RANDOM_ITEMS;
      while (packet_items < target) begin
         make_random_packet();
         send_packet();
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_header_edges();
      test_long_header();
      test_stream_frames();
      test_backpressure();
      test_random_packets();
      req_tvalid <= 1'b0;
      while (parsed_items.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Checked %0d results (%0d frame headers, %0d end statuses)",
               results_checked, frames_checked, ends_checked);
      $display("from %0d bytes in %0d packets; covered both header forms, cut-off fields,",
               packet_items, packets_sent);
      $display("restarts, stray bytes and a %0d-cycle hold", HOLD_CYCLES);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
sv/spbp_pkg.sv
sv/spbp_parser.sv
sv/spbp_queue.sv
sv/spbp_emitter.sv
sv/stream_packet_byte_parser_unit.sv
tb/tb_stream_packet_byte_parser_unit.sv
